[sv/mhts_pkg.sv]
`timescale 1ns / 1ps
package mhts_pkg;

	localparam int CAPACITY = 32;
	localparam int ID_COUNT = 64;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int FILL_W   = $clog2(CAPACITY + 1);
	localparam int ID_W     = 6;
	localparam int TO_W     = 24;
	localparam int EXP_W    = 48;
	localparam int POS_W    = $clog2(ID_COUNT);

	// command codes
	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_ADJUST = 3'd1;
	localparam logic [2:0] CMD_TICK   = 3'd2;
	localparam logic [2:0] CMD_POP    = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_EXPIRED = 2'd0;
	localparam logic [1:0] KIND_NEXT    = 2'd1;
	localparam logic [1:0] KIND_ACK     = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	typedef enum logic [2:0] {RD_ROOT, RD_LAST, RD_LEFT, RD_RIGHT, RD_PARENT} rd_sel_t;
	typedef enum logic [1:0] {ID_ZERO, ID_ITEM, ID_WHO} id_sel_t;
	typedef enum logic [1:0] {HOLE_FILL, HOLE_POS, HOLE_ZERO} hole_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic      ld_item;
		logic      slot_rd;
		rd_sel_t   rd_sel;
		logic      pos_rd;
		logic      ld_cur_item;
		logic      ld_cur_rd;
		logic      ld_hole;
		hole_sel_t hole_sel;
		logic      ld_best;
		logic      pick_right;
		logic      move_child;
		logic      move_parent;
		logic      write_cur;
		logic      ld_who;
		logic      fill_inc;
		logic      fill_dec;
		logic      clr_all;
		logic      out_load;
		logic [1:0] out_kind;
		id_sel_t   out_id_sel;
		logic      out_last;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] cmd;
		logic       present;
		logic       full;
		logic       fill_zero;
		logic       fill_one;
		logic       has_left;
		logic       has_right;
		logic       cur_lt_best;
		logic       cur_lt_rd;
		logic       hole_zero;
		logic       root_expired;
		logic       out_free;
	} dp_stat_t;

endpackage

[sv/min_heap_timeout_scheduler_unit.sv]
`timescale 1ns / 1ps
// Timer queue on a binary min-heap, one word at a time.
// Add/adjust sift the entry down or up the heap; a tick reports and removes each expired
// timer in turn, then reports the time left on the next one; clear and errors go straight to the report.
// Throughput: one word per pass, set by the single-port slot memory walked level by level.
// Reset: arst_n clears fill count, presence bits, controller and output valid.
module min_heap_timeout_scheduler_unit import mhts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       cmd,
	input  logic [ID_W-1:0]  timer_id,
	input  logic [TO_W-1:0]  timeout_ms,
	input  logic [EXP_W-1:0] now_ms,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       kind,
	output logic [ID_W-1:0]  result_id,
	output logic [TO_W-1:0]  next_ms,
	output logic             heap_empty,
	output logic             last
);

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	mhts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	mhts_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.cmd        (cmd),
		.timer_id   (timer_id),
		.timeout_ms (timeout_ms),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.result_id  (result_id),
		.next_ms    (next_ms),
		.heap_empty (heap_empty),
		.last       (last)
	);

endmodule

[sv/mhts_datapath.sv]
`timescale 1ns / 1ps
module mhts_datapath import mhts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        ctl,
	output dp_stat_t         stat,
	input  logic [2:0]       cmd,
	input  logic [ID_W-1:0]  timer_id,
	input  logic [TO_W-1:0]  timeout_ms,
	input  logic [EXP_W-1:0] now_ms,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       kind,
	output logic [ID_W-1:0]  result_id,
	output logic [TO_W-1:0]  next_ms,
	output logic             heap_empty,
	output logic             last
);

	localparam int ENT_W = EXP_W + ID_W;

	// heap slots {expiry, owner} and id -> slot map
	logic [ENT_W-1:0]  slot_mem [CAPACITY];
	logic [SLOT_W-1:0] pos_mem  [ID_COUNT];

	logic [2:0]        cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [EXP_W-1:0]  exp_q;
	logic [EXP_W-1:0]  now_q;
	logic [ENT_W-1:0]  cur_q;
	logic [ENT_W-1:0]  best_q;
	logic [SLOT_W-1:0] best_idx_q;
	logic [ENT_W-1:0]  rd_q;
	logic [SLOT_W-1:0] rd_idx_q;
	logic [SLOT_W-1:0] pos_rd_q;
	logic [SLOT_W-1:0] hole_q;
	logic [FILL_W-1:0] fill_q;
	logic [ID_COUNT-1:0] present_q;
	logic [ID_W-1:0]   who_q;

	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [ID_W-1:0]   result_id_q;
	logic [TO_W-1:0]   next_ms_q;
	logic              heap_empty_q;
	logic              last_q;

	logic [EXP_W:0]    sum;
	logic [EXP_W-1:0]  expiry;
	logic [FILL_W:0]   left_idx;
	logic [FILL_W:0]   right_idx;
	logic [SLOT_W-1:0] parent_idx;
	logic [SLOT_W-1:0] rd_addr;
	logic [FILL_W-1:0] last_idx;
	logic [EXP_W-1:0]  diff;
	logic [TO_W-1:0]   left_ms;
	logic              slot_we;
	logic [ENT_W-1:0]  slot_wdata;
	logic [ID_W-1:0]   pos_wid;
	logic              out_free;

	// saturating expiry
	assign sum    = {1'b0, now_ms} + {{(EXP_W + 1 - TO_W){1'b0}}, timeout_ms};
	assign expiry = sum[EXP_W] ? {EXP_W{1'b1}} : sum[EXP_W-1:0];

	// heap neighbors of the hole
	assign left_idx   = {1'b0, hole_q, 1'b1};
	assign right_idx  = left_idx + {{FILL_W{1'b0}}, 1'b1};
	assign parent_idx = (hole_q - {{(SLOT_W-1){1'b0}}, 1'b1}) >> 1;
	assign last_idx   = fill_q - {{(FILL_W-1){1'b0}}, 1'b1};

	always_comb begin
		case (ctl.rd_sel)
			RD_ROOT:   rd_addr = '0;
			RD_LAST:   rd_addr = last_idx[SLOT_W-1:0];
			RD_LEFT:   rd_addr = left_idx[SLOT_W-1:0];
			RD_RIGHT:  rd_addr = right_idx[SLOT_W-1:0];
			RD_PARENT: rd_addr = parent_idx;
			default:   rd_addr = '0;
		endcase
	end

	// slot and map write port
	assign slot_we = ctl.move_child | ctl.move_parent | ctl.write_cur;
	always_comb begin
		if (ctl.move_child) begin
			slot_wdata = best_q;
		end else if (ctl.move_parent) begin
			slot_wdata = rd_q;
		end else begin
			slot_wdata = cur_q;
		end
	end
	assign pos_wid = slot_wdata[ID_W-1:0];

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[hole_q]  <= slot_wdata;
			pos_mem[pos_wid] <= hole_q;
		end
		if (ctl.slot_rd) begin
			rd_q     <= slot_mem[rd_addr];
			rd_idx_q <= rd_addr;
		end
		if (ctl.pos_rd) begin
			pos_rd_q <= pos_mem[id_q];
		end
	end

	// word, moving entry and best child
	always_ff @(posedge clk) begin
		if (ctl.ld_item) begin
			cmd_q <= cmd;
			id_q  <= timer_id;
			exp_q <= expiry;
			now_q <= now_ms;
		end
		if (ctl.ld_cur_item) begin
			cur_q <= {exp_q, id_q};
		end else if (ctl.ld_cur_rd) begin
			cur_q <= rd_q;
		end
		if (ctl.ld_best || (ctl.pick_right &&
				rd_q[ENT_W-1:ID_W] < best_q[ENT_W-1:ID_W])) begin
			best_q     <= rd_q;
			best_idx_q <= rd_idx_q;
		end
		if (ctl.ld_who) begin
			who_q <= rd_q[ID_W-1:0];
		end
		if (ctl.move_child) begin
			hole_q <= best_idx_q;
		end else if (ctl.move_parent) begin
			hole_q <= rd_idx_q;
		end else if (ctl.ld_hole) begin
			case (ctl.hole_sel)
				HOLE_FILL: hole_q <= fill_q[SLOT_W-1:0];
				HOLE_POS:  hole_q <= pos_rd_q;
				HOLE_ZERO: hole_q <= '0;
				default:   hole_q <= '0;
			endcase
		end
	end

	// fill count and presence bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			present_q <= '0;
		end else begin
			if (ctl.clr_all) begin
				fill_q    <= '0;
				present_q <= '0;
			end else if (ctl.fill_inc) begin
				fill_q          <= fill_q + {{(FILL_W-1){1'b0}}, 1'b1};
				present_q[id_q] <= 1'b1;
			end else if (ctl.fill_dec) begin
				fill_q           <= last_idx;
				present_q[who_q] <= 1'b0;
			end
		end
	end

	// time left on the root entry
	assign diff    = rd_q[ENT_W-1:ID_W] - now_q;
	assign left_ms = (fill_q == '0 || rd_q[ENT_W-1:ID_W] <= now_q) ? '0 :
		(diff[EXP_W-1:TO_W] != '0) ? {TO_W{1'b1}} : diff[TO_W-1:0];

	// output register
	assign out_free = !out_valid_q || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			kind_q       <= ctl.out_kind;
			next_ms_q    <= (ctl.out_kind == KIND_NEXT) ? left_ms : '0;
			heap_empty_q <= (fill_q == '0);
			last_q       <= ctl.out_last;
			case (ctl.out_id_sel)
				ID_ZERO: result_id_q <= '0;
				ID_ITEM: result_id_q <= id_q;
				ID_WHO:  result_id_q <= who_q;
				default: result_id_q <= '0;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign result_id  = result_id_q;
	assign next_ms    = next_ms_q;
	assign heap_empty = heap_empty_q;
	assign last       = last_q;

	// status
	assign stat.cmd          = cmd_q;
	assign stat.present      = present_q[id_q];
	assign stat.full         = (fill_q >= FILL_W'(CAPACITY));
	assign stat.fill_zero    = (fill_q == '0);
	assign stat.fill_one     = (fill_q == FILL_W'(1));
	assign stat.has_left     = (left_idx < {1'b0, fill_q});
	assign stat.has_right    = (right_idx < {1'b0, fill_q});
	assign stat.cur_lt_best  = cur_q[ENT_W-1:ID_W] < best_q[ENT_W-1:ID_W];
	assign stat.cur_lt_rd    = cur_q[ENT_W-1:ID_W] < rd_q[ENT_W-1:ID_W];
	assign stat.hole_zero    = (hole_q == '0);
	assign stat.root_expired = rd_q[ENT_W-1:ID_W] <= now_q;
	assign stat.out_free     = out_free;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CAPACITY))
		else $error("fill count above capacity");
	a_present_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(present_q) == int'(fill_q))
		else $error("presence bits disagree with fill count");
	a_hole_live: assert property (@(posedge clk) disable iff (!arst_n)
		slot_we |-> ({1'b0, hole_q} < fill_q))
		else $error("slot write outside live heap");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> out_free)
		else $error("result overwritten before taken");

endmodule

[sv/mhts_ctrl.sv]
`timescale 1ns / 1ps
module mhts_ctrl import mhts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t ctl
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_POS_WAIT, S_ROOT_RD, S_ROOT_CHK, S_REMOVE,
		S_DN_RD1, S_DN_RD2, S_DN_PICK, S_DN_CMP, S_UP, S_UP_CMP, S_FIN, S_EMIT
	} state_t;

	state_t     state_q;
	logic [1:0] emit_kind_q;
	id_sel_t    emit_id_q;
	logic       emit_last_q;
	logic       emit_more_q;

	// state and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			emit_kind_q <= KIND_ACK;
			emit_id_q   <= ID_ZERO;
			emit_last_q <= 1'b1;
			emit_more_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					emit_more_q <= 1'b0;
					emit_last_q <= 1'b1;
					emit_kind_q <= KIND_ERROR;
					emit_id_q   <= ID_ZERO;
					state_q     <= S_EMIT;
					case (stat.cmd)
						CMD_ADD, CMD_ADJUST: begin
							if (stat.present) begin
								emit_kind_q <= KIND_ACK;
								emit_id_q   <= ID_ITEM;
								state_q     <= S_POS_WAIT;
							end else if (stat.cmd == CMD_ADD && !stat.full) begin
								emit_kind_q <= KIND_ACK;
								emit_id_q   <= ID_ITEM;
								state_q     <= S_DN_RD1;
							end
						end
						CMD_TICK: state_q <= S_ROOT_RD;
						CMD_POP: begin
							if (!stat.fill_zero) state_q <= S_ROOT_RD;
						end
						CMD_CLEAR: emit_kind_q <= KIND_ACK;
						default: ;
					endcase
				end
				S_POS_WAIT: state_q <= S_DN_RD1;
				S_ROOT_RD:  state_q <= S_ROOT_CHK;
				S_ROOT_CHK: begin
					if (stat.cmd == CMD_POP) begin
						emit_kind_q <= KIND_ACK;
						emit_id_q   <= ID_WHO;
						emit_last_q <= 1'b1;
						emit_more_q <= 1'b0;
						state_q     <= S_REMOVE;
					end else if (!stat.fill_zero && stat.root_expired) begin
						emit_kind_q <= KIND_EXPIRED;
						emit_id_q   <= ID_WHO;
						emit_last_q <= 1'b0;
						emit_more_q <= 1'b1;
						state_q     <= S_REMOVE;
					end else begin
						emit_kind_q <= KIND_NEXT;
						emit_id_q   <= ID_ZERO;
						emit_last_q <= 1'b1;
						emit_more_q <= 1'b0;
						state_q     <= S_EMIT;
					end
				end
				S_REMOVE: state_q <= stat.fill_one ? S_EMIT : S_DN_RD1;
				S_DN_RD1: state_q <= stat.has_left ? S_DN_RD2 : S_UP;
				S_DN_RD2: state_q <= stat.has_right ? S_DN_PICK : S_DN_CMP;
				S_DN_PICK: state_q <= S_DN_CMP;
				S_DN_CMP: state_q <= stat.cur_lt_best ? S_UP : S_DN_RD1;
				S_UP: state_q <= stat.hole_zero ? S_FIN : S_UP_CMP;
				S_UP_CMP: state_q <= stat.cur_lt_rd ? S_UP : S_FIN;
				S_FIN: state_q <= S_EMIT;
				S_EMIT: begin
					if (stat.out_free) state_q <= emit_more_q ? S_ROOT_RD : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// datapath commands
	always_comb begin
		ctl            = '0;
		ctl.rd_sel     = RD_ROOT;
		ctl.hole_sel   = HOLE_FILL;
		ctl.out_id_sel = emit_id_q;
		ctl.out_kind   = emit_kind_q;
		ctl.out_last   = emit_last_q;
		case (state_q)
			S_IDLE: ctl.ld_item = in_valid;
			S_DISPATCH: begin
				case (stat.cmd)
					CMD_ADD, CMD_ADJUST: begin
						if (stat.present) begin
							ctl.pos_rd = 1'b1;
						end else if (stat.cmd == CMD_ADD && !stat.full) begin
							ctl.ld_cur_item = 1'b1;
							ctl.ld_hole     = 1'b1;
							ctl.hole_sel    = HOLE_FILL;
							ctl.fill_inc    = 1'b1;
						end
					end
					CMD_CLEAR: ctl.clr_all = 1'b1;
					default: ;
				endcase
			end
			S_POS_WAIT: begin
				ctl.ld_cur_item = 1'b1;
				ctl.ld_hole     = 1'b1;
				ctl.hole_sel    = HOLE_POS;
			end
			S_ROOT_RD: begin
				ctl.slot_rd = 1'b1;
				ctl.rd_sel  = RD_ROOT;
			end
			S_ROOT_CHK: begin
				if (stat.cmd == CMD_POP || (!stat.fill_zero && stat.root_expired)) begin
					ctl.ld_who  = 1'b1;
					ctl.slot_rd = 1'b1;
					ctl.rd_sel  = RD_LAST;
				end
			end
			S_REMOVE: begin
				ctl.fill_dec  = 1'b1;
				ctl.ld_cur_rd = 1'b1;
				ctl.ld_hole   = 1'b1;
				ctl.hole_sel  = HOLE_ZERO;
			end
			S_DN_RD1: begin
				ctl.slot_rd = stat.has_left;
				ctl.rd_sel  = RD_LEFT;
			end
			S_DN_RD2: begin
				ctl.ld_best = 1'b1;
				ctl.slot_rd = stat.has_right;
				ctl.rd_sel  = RD_RIGHT;
			end
			S_DN_PICK: ctl.pick_right = 1'b1;
			S_DN_CMP:  ctl.move_child = !stat.cur_lt_best;
			S_UP: begin
				ctl.slot_rd = !stat.hole_zero;
				ctl.rd_sel  = RD_PARENT;
			end
			S_UP_CMP: ctl.move_parent = stat.cur_lt_rd;
			S_FIN:    ctl.write_cur   = 1'b1;
			S_EMIT:   ctl.out_load    = stat.out_free;
			default: ;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_DISPATCH)
		else $error("accepted word not dispatched");
	a_move_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.move_child, ctl.move_parent, ctl.write_cur}))
		else $error("two slot writes in one cycle");
	a_emit_more: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && ctl.out_load) |-> (emit_more_q != emit_last_q))
		else $error("result marks last yet continues");

endmodule
